// ----- src/smh_pkg.sv -----
// ----------------------------------------------------------------------------
// smh_pkg
// Shared constants, types and tables for the spherical Mexican hat evaluator.
// ----------------------------------------------------------------------------
package smh_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int OUT_WIDTH_DEF   = 32;
    localparam int SCALE_WIDTH     = 16;

    // internal fixed point formats
    localparam int SQ_WIDTH     = 33;   // one squared difference, Q.28
    localparam int D_WIDTH      = 30;   // clamped chordal distance, Q.28
    localparam int S2_WIDTH     = 32;   // scale squared
    localparam int Y2_WIDTH     = 60;   // full y2 quotient, Q.28
    localparam int Y2_LIVE      = 51;   // y2 bits that matter below the cutoff
    localparam int Y2S_WIDTH    = 37;   // y2 >> 14
    localparam int UNUM_WIDTH   = Y2_LIVE + 12;
    localparam int U_WIDTH      = 31;   // y2 / s^2, Q.24
    localparam int KS_WIDTH     = 39;
    localparam int CUT_SHIFT    = 19;

    localparam logic [KS_WIDTH-1:0] KS_NUM     = 39'd438641676032;  // K << 8
    localparam logic [31:0]         HALF_LOG2E = 32'hB8AA3B29;
    localparam logic [30:0]         LN2_Q31    = 31'h58B90BFC;
    localparam logic [31:0]         ONE_Q31    = 32'h8000_0000;
    localparam int                  EXP_TERMS  = 12;

    typedef enum logic [1:0] {
        CFG_CENTRE_X = 2'd0,
        CFG_CENTRE_Y = 2'd1,
        CFG_CENTRE_Z = 2'd2,
        CFG_SCALE    = 2'd3
    } cfg_index_t;

    // floor(2^32 / k) for the series divisors
    function automatic logic [32:0] horner_recip(input int k);
        logic [32:0] r;
        case (k)
            1:       r = 33'd4294967296;
            2:       r = 33'd2147483648;
            3:       r = 33'd1431655765;
            4:       r = 33'd1073741824;
            5:       r = 33'd858993459;
            6:       r = 33'd715827882;
            7:       r = 33'd613566756;
            8:       r = 33'd536870912;
            9:       r = 33'd477218588;
            10:      r = 33'd429496729;
            11:      r = 33'd390451572;
            12:      r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/spherical_mexican_hat_eval_top.sv -----
// ----------------------------------------------------------------------------
// spherical_mexican_hat_eval_top
// Spherical Mexican hat wavelet, one point per cycle while out_stall does not hold a result, through a deep pipeline.
//
//   channel   direction  handshake          payload
//   in        to block   in_valid/in_stall  point_x, point_y, point_z
//   out       from block out_valid/out_stall wavelet_value
//   cfg       to block   cfg_we             cfg_index, cfg_data
//
// one point enters per cycle unless the pipeline is stalled; the pipeline runs through
// the three bit-per-stage dividers (y2, y2/s^2, K/s) and the twelve-term exp series
// rst_n clears all valid bits and loads the default centre and scale
// a stalled result freezes the whole pipeline; in_stall follows it
// ----------------------------------------------------------------------------
module spherical_mexican_hat_eval_top #(
    parameter int COORD_WIDTH = smh_pkg::COORD_WIDTH_DEF,
    parameter int OUT_WIDTH   = smh_pkg::OUT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     point_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [OUT_WIDTH-1:0]       wavelet_value,
    input  logic                              cfg_we,
    input  smh_pkg::cfg_index_t               cfg_index,
    input  logic [((COORD_WIDTH > smh_pkg::SCALE_WIDTH) ? COORD_WIDTH
                   : smh_pkg::SCALE_WIDTH)-1:0] cfg_data
);
    import smh_pkg::*;

    localparam int S1_SIDE = S2_WIDTH + SCALE_WIDTH;
    localparam int S2_SIDE = 1 + Y2S_WIDTH + SCALE_WIDTH;
    localparam int S3_SIDE = 1 + Y2S_WIDTH + U_WIDTH;

    logic signed [COORD_WIDTH-1:0] centre_x_reg, centre_y_reg, centre_z_reg;
    logic [SCALE_WIDTH-1:0]        scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= COORD_WIDTH'(1) << (COORD_WIDTH - 2);
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            scale_reg    <= SCALE_WIDTH'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTRE_X: centre_x_reg <= cfg_data[COORD_WIDTH-1:0];
                CFG_CENTRE_Y: centre_y_reg <= cfg_data[COORD_WIDTH-1:0];
                CFG_CENTRE_Z: centre_z_reg <= cfg_data[COORD_WIDTH-1:0];
                CFG_SCALE:    scale_reg    <= cfg_data[SCALE_WIDTH-1:0];
                default:      scale_reg    <= scale_reg;
            endcase
        end
    end

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // distance
    logic                   fr_valid;
    logic [D_WIDTH-1:0]     fr_d;
    logic [SCALE_WIDTH-1:0] fr_s;
    logic [S2_WIDTH-1:0]    fr_s2;

    smh_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .centre_x  (centre_x_reg),
        .centre_y  (centre_y_reg),
        .centre_z  (centre_z_reg),
        .scale     (scale_reg),
        .out_valid (fr_valid),
        .d         (fr_d),
        .s         (fr_s),
        .s2        (fr_s2)
    );

    // y2 = 4d / (4 - d)
    logic                 dv1_valid;
    logic [Y2_WIDTH-1:0]  dv1_quo;
    logic [S1_SIDE-1:0]   dv1_side;

    smh_div_pipe #(
        .NUM_W  (Y2_WIDTH),
        .DEN_W  (D_WIDTH + 1),
        .SIDE_W (S1_SIDE)
    ) u_div_y2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .num       ({fr_d, {D_WIDTH{1'b0}}}),
        .den       (((D_WIDTH + 1)'(1) << D_WIDTH) - {1'b0, fr_d}),
        .side      ({fr_s2, fr_s}),
        .out_valid (dv1_valid),
        .quo       (dv1_quo),
        .out_side  (dv1_side)
    );

    logic [S2_WIDTH-1:0]    dv1_s2;
    logic [SCALE_WIDTH-1:0] dv1_s;
    logic                   dv1_zero;

    assign dv1_s2   = dv1_side[S1_SIDE-1:SCALE_WIDTH];
    assign dv1_s    = dv1_side[SCALE_WIDTH-1:0];
    assign dv1_zero = (dv1_quo >= (Y2_WIDTH'(dv1_s2) << CUT_SHIFT));

    // u = y2 / s^2
    logic                  dv2_valid;
    logic [UNUM_WIDTH-1:0] dv2_quo;
    logic [S2_SIDE-1:0]    dv2_side;

    smh_div_pipe #(
        .NUM_W  (UNUM_WIDTH),
        .DEN_W  (S2_WIDTH),
        .SIDE_W (S2_SIDE)
    ) u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv1_valid),
        .num       ({dv1_quo[Y2_LIVE-1:0], 12'd0}),
        .den       (dv1_s2),
        .side      ({dv1_zero, dv1_quo[Y2_LIVE-1:14], dv1_s}),
        .out_valid (dv2_valid),
        .quo       (dv2_quo),
        .out_side  (dv2_side)
    );

    // K / s
    logic                dv3_valid;
    logic [KS_WIDTH-1:0] dv3_quo;
    logic [S3_SIDE-1:0]  dv3_side;

    smh_div_pipe #(
        .NUM_W  (KS_WIDTH),
        .DEN_W  (SCALE_WIDTH),
        .SIDE_W (S3_SIDE)
    ) u_div_ks (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv2_valid),
        .num       (KS_NUM),
        .den       (dv2_side[SCALE_WIDTH-1:0]),
        .side      ({dv2_side[S2_SIDE-1:SCALE_WIDTH], dv2_quo[U_WIDTH-1:0]}),
        .out_valid (dv3_valid),
        .quo       (dv3_quo),
        .out_side  (dv3_side)
    );

    smh_back #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (dv3_valid),
        .ks            (dv3_quo),
        .zero          (dv3_side[S3_SIDE-1]),
        .y2s           (dv3_side[S3_SIDE-2:U_WIDTH]),
        .u             (dv3_side[U_WIDTH-1:0]),
        .out_valid     (out_valid),
        .wavelet_value (wavelet_value)
    );

endmodule

// ----- src/smh_front.sv -----
// ----------------------------------------------------------------------------
// smh_front
// Squared chordal distance to the centre, clamp below four, scale squared.
// ----------------------------------------------------------------------------
module smh_front #(
    parameter int COORD_WIDTH = smh_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_y,
    input  logic signed [COORD_WIDTH-1:0]        point_z,
    input  logic signed [COORD_WIDTH-1:0]        centre_x,
    input  logic signed [COORD_WIDTH-1:0]        centre_y,
    input  logic signed [COORD_WIDTH-1:0]        centre_z,
    input  logic [smh_pkg::SCALE_WIDTH-1:0]      scale,
    output logic                                 out_valid,
    output logic [smh_pkg::D_WIDTH-1:0]          d,
    output logic [smh_pkg::SCALE_WIDTH-1:0]      s,
    output logic [smh_pkg::S2_WIDTH-1:0]         s2
);
    import smh_pkg::*;

    localparam int MAG_W  = COORD_WIDTH + 1;
    localparam int SQF_W  = 2 * MAG_W;
    localparam int SH_DN  = (COORD_WIDTH >= 16) ? 2 * COORD_WIDTH - 32 : 0;
    localparam int SH_UP  = (COORD_WIDTH >= 16) ? 0 : 32 - 2 * COORD_WIDTH;
    localparam int SUM_W  = SQ_WIDTH + 2;

    function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                                  input logic [COORD_WIDTH-1:0] b);
        logic [MAG_W-1:0] df;
        df = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        return df[MAG_W-1] ? (~df + MAG_W'(1)) : df;
    endfunction

    function automatic logic [SQ_WIDTH-1:0] to_q28(input logic [MAG_W-1:0] m);
        logic [SQF_W-1:0] sq;
        sq = SQF_W'(m) * SQF_W'(m);
        return SQ_WIDTH'(sq >> SH_DN) << SH_UP;
    endfunction

    logic                   v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0]       mx_reg, my_reg, mz_reg;
    logic [SCALE_WIDTH-1:0] s1_reg, s2s_reg, s3_reg;
    logic [SQ_WIDTH-1:0]    qx_reg, qy_reg, qz_reg;
    logic [S2_WIDTH-1:0]    ss2_reg, ss3_reg;
    logic [D_WIDTH-1:0]     d_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [D_WIDTH-1:0]     d_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(qx_reg) + SUM_W'(qy_reg) + SUM_W'(qz_reg);
        // far from centre clamps one lsb below four
        if (sum_next >= (SUM_W'(1) << D_WIDTH))
            d_next = '1;
        else
            d_next = sum_next[D_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= abs_diff(point_x, centre_x);
            my_reg  <= abs_diff(point_y, centre_y);
            mz_reg  <= abs_diff(point_z, centre_z);
            s1_reg  <= (scale == '0) ? SCALE_WIDTH'(1) : scale;
            qx_reg  <= to_q28(mx_reg);
            qy_reg  <= to_q28(my_reg);
            qz_reg  <= to_q28(mz_reg);
            s2s_reg <= s1_reg;
            ss2_reg <= S2_WIDTH'(s1_reg) * S2_WIDTH'(s1_reg);
            d_reg   <= d_next;
            s3_reg  <= s2s_reg;
            ss3_reg <= ss2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign d         = d_reg;
    assign s         = s3_reg;
    assign s2        = ss3_reg;

endmodule

// ----- src/smh_div_pipe.sv -----
// ----------------------------------------------------------------------------
// smh_div_pipe
// Restoring divider, one quotient bit per register stage, with side data.
// ----------------------------------------------------------------------------
module smh_div_pipe #(
    parameter int NUM_W  = 60,
    parameter int DEN_W  = 31,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [NUM_W+1];
    logic [DEN_W-1:0]  rem_reg  [NUM_W+1];
    logic [NUM_W-1:0]  nq_reg   [NUM_W+1];
    logic [DEN_W-1:0]  den_reg  [NUM_W+1];
    logic [SIDE_W-1:0] side_reg [NUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            nq_reg[0]   <= num;
            den_reg[0]  <= den;
            side_reg[0] <= side;
        end
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[i], nq_reg[i][NUM_W-1]};
            diff     = trial - {1'b0, den_reg[i]};
            ge       = (trial >= {1'b0, den_reg[i]});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                nq_reg[i+1]   <= {nq_reg[i][NUM_W-2:0], ge};
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign quo       = nq_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

// ----- src/smh_back.sv -----
// ----------------------------------------------------------------------------
// smh_back
// Exponential series, amplitude products, final rounding and saturation.
// ----------------------------------------------------------------------------
module smh_back #(
    parameter int OUT_WIDTH = smh_pkg::OUT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [smh_pkg::KS_WIDTH-1:0]    ks,
    input  logic                            zero,
    input  logic [smh_pkg::Y2S_WIDTH-1:0]   y2s,
    input  logic [smh_pkg::U_WIDTH-1:0]     u,
    output logic                            out_valid,
    output logic signed [OUT_WIDTH-1:0]     wavelet_value
);
    import smh_pkg::*;

    localparam int OUT_FRAC = OUT_WIDTH / 2;
    localparam int SH_BASE  = 70 - OUT_FRAC;
    localparam int XW       = 92 - SH_BASE;
    localparam int CMP_W    = XW + OUT_WIDTH;
    localparam int NT       = EXP_TERMS;

    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [6:0]  n;
        logic [59:0] mag;
        logic [30:0] w;
    } side_t;

    localparam logic [22:0] TWO_Q16 = 23'h20000;

    // first stage: exponent split, b16 partial products, 2 - u
    logic        b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    logic        b1_zero_reg, b2_zero_reg, b3_zero_reg;
    logic        b1_neg_reg, b2_neg_reg, b3_neg_reg;
    logic [22:0] b1_cmag_reg, b2_cmag_reg;
    logic [6:0]  b1_n_reg, b2_n_reg, b3_n_reg;
    logic [30:0] b1_f_reg;
    logic [57:0] b1_plo_reg, b1_phi_reg;
    logic [30:0] b2_w_reg, b3_w_reg;
    logic [36:0] b2_kb_reg;
    logic [41:0] b3_ml_reg, b3_mh_reg;

    logic [62:0] t_next;
    logic [37:0] b16_next;
    logic [22:0] us_next;
    logic [61:0] wp_next;
    logic [76:0] kb_next;
    logic [60:0] mag_next;

    always_comb
    begin
        t_next   = 63'(u) * 63'(HALF_LOG2E);
        b16_next = (38'(1) << 16) + 38'(y2s);
        us_next  = u[30:8];
        wp_next  = 62'(b1_f_reg) * 62'(LN2_Q31);
        kb_next  = (77'(b1_phi_reg) << 19) + 77'(b1_plo_reg);
        mag_next = (61'(b3_mh_reg) << 19) + 61'(b3_ml_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_v_reg <= in_valid;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
        end
    end

    side_t       hs_side [NT+1];
    logic [31:0] hs_r    [NT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_zero_reg <= zero;
            b1_neg_reg  <= (us_next > TWO_Q16);
            b1_cmag_reg <= (us_next > TWO_Q16) ? (us_next - TWO_Q16) : (TWO_Q16 - us_next);
            b1_n_reg    <= t_next[62:56];
            b1_f_reg    <= t_next[55:25];
            b1_plo_reg  <= 58'(ks) * 58'(b16_next[18:0]);
            b1_phi_reg  <= 58'(ks) * 58'(b16_next[37:19]);

            b2_zero_reg <= b1_zero_reg;
            b2_neg_reg  <= b1_neg_reg;
            b2_cmag_reg <= b1_cmag_reg;
            b2_n_reg    <= b1_n_reg;
            b2_w_reg    <= wp_next[61:31];
            b2_kb_reg   <= kb_next[60:24];

            b3_zero_reg <= b2_zero_reg;
            b3_neg_reg  <= b2_neg_reg;
            b3_n_reg    <= b2_n_reg;
            b3_w_reg    <= b2_w_reg;
            b3_ml_reg   <= 42'(b2_kb_reg[18:0]) * 42'(b2_cmag_reg);
            b3_mh_reg   <= 42'(b2_kb_reg[36:19]) * 42'(b2_cmag_reg);

            hs_side[0].zero <= b3_zero_reg;
            hs_side[0].neg  <= b3_neg_reg;
            hs_side[0].n    <= b3_n_reg;
            hs_side[0].w    <= b3_w_reg;
            hs_side[0].mag  <= mag_next[59:0];
            hs_r[0]         <= ONE_Q31;
        end
    end

    // series for exp(-w), three stages per term
    logic        hs_v   [NT+1];
    logic        ha_v   [NT];
    logic        hb_v   [NT];
    side_t       ha_side[NT];
    side_t       hb_side[NT];
    logic [31:0] ha_p   [NT];
    logic [31:0] hb_p   [NT];
    logic [31:0] hb_q   [NT];

    assign hs_v[0] = b4_v_reg;

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam int          KT = NT - j;
        localparam logic [32:0] RK = horner_recip(KT);

        logic [62:0] wr;
        logic [64:0] pr;
        logic [35:0] rem;
        logic [31:0] q;

        always_comb
        begin
            wr  = 63'(hs_side[j].w) * 63'(hs_r[j]);
            pr  = 65'(ha_p[j]) * 65'(RK);
            rem = 36'(hb_p[j]) - 36'(hb_q[j]) * 36'(KT);
            q   = (rem >= 36'(KT)) ? hb_q[j] + 32'd1 : hb_q[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ha_v[j]   <= 1'b0;
                hb_v[j]   <= 1'b0;
                hs_v[j+1] <= 1'b0;
            end
            else if (en)
            begin
                ha_v[j]   <= hs_v[j];
                hb_v[j]   <= ha_v[j];
                hs_v[j+1] <= hb_v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ha_p[j]      <= wr[62:31];
                ha_side[j]   <= hs_side[j];
                hb_p[j]      <= ha_p[j];
                hb_q[j]      <= pr[63:32];
                hb_side[j]   <= ha_side[j];
                hs_r[j+1]    <= ONE_Q31 - q;
                hs_side[j+1] <= hb_side[j];
            end
        end
    end

    // final product, rounding shift, saturation
    logic        f1_v_reg, f2_v_reg, f3_v_reg, f4_v_reg;
    logic        f1_zero_reg, f2_zero_reg, f3_zero_reg;
    logic        f1_neg_reg, f2_neg_reg, f3_neg_reg;
    logic [6:0]  f1_n_reg, f2_n_reg;
    logic [61:0] f1_pl_reg, f1_ph_reg;
    logic [91:0] f2_prod_reg;
    logic [XW-1:0] f3_x_reg;
    logic signed [OUT_WIDTH-1:0] wavelet_reg;

    logic [7:0]       shamt;
    logic [91:0]      shifted;
    logic [XW:0]      inc;
    logic [CMP_W-1:0] res;
    logic [CMP_W-1:0] pmax;
    logic [CMP_W-1:0] lim;
    logic [OUT_WIDTH-1:0] wavelet_next;

    always_comb
    begin
        shamt   = 8'(SH_BASE) + 8'(f2_n_reg);
        shifted = f2_prod_reg >> shamt;
        inc     = (XW + 1)'(f3_x_reg) + (XW + 1)'(1);
        res     = CMP_W'(inc[XW:1]);
        pmax    = CMP_W'((64'(1) << (OUT_WIDTH - 1)) - 64'(1));
        if (f3_zero_reg)
        begin
            lim          = '0;
            wavelet_next = '0;
        end
        else if (f3_neg_reg)
        begin
            lim          = (res > pmax + CMP_W'(1)) ? pmax + CMP_W'(1) : res;
            wavelet_next = OUT_WIDTH'(~lim + CMP_W'(1));
        end
        else
        begin
            lim          = (res > pmax) ? pmax : res;
            wavelet_next = OUT_WIDTH'(lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= hs_v[NT];
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_zero_reg <= hs_side[NT].zero;
            f1_neg_reg  <= hs_side[NT].neg;
            f1_n_reg    <= hs_side[NT].n;
            f1_pl_reg   <= 62'(hs_side[NT].mag[29:0]) * 62'(hs_r[NT]);
            f1_ph_reg   <= 62'(hs_side[NT].mag[59:30]) * 62'(hs_r[NT]);

            f2_zero_reg <= f1_zero_reg;
            f2_neg_reg  <= f1_neg_reg;
            f2_n_reg    <= f1_n_reg;
            f2_prod_reg <= (92'(f1_ph_reg) << 30) + 92'(f1_pl_reg);

            f3_zero_reg <= f2_zero_reg;
            f3_neg_reg  <= f2_neg_reg;
            f3_x_reg    <= shifted[XW-1:0];

            wavelet_reg <= signed'(wavelet_next);
        end
    end

    assign out_valid     = f4_v_reg;
    assign wavelet_value = wavelet_reg;

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && f3_v_reg && f3_zero_reg) |=> (wavelet_value == '0))
        else $error("underflow beat not zero");

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (en && f3_v_reg && !f3_neg_reg) |=> !wavelet_value[OUT_WIDTH-1])
        else $error("positive beat came out negative");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (en && f3_v_reg && f3_neg_reg)
        |=> (wavelet_value[OUT_WIDTH-1] || (wavelet_value == '0)))
        else $error("negative beat came out positive");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        hs_v[NT] |-> (hs_r[NT] <= ONE_Q31))
        else $error("exp series above one");

endmodule
